>>> rtl/elgamal_modexp_engine_core_defines.svh
// Assertion macros for the ElGamal engine core.
// No dependencies; included by the top level only.
`ifndef ELGAMAL_MODEXP_ENGINE_CORE_DEFINES_SVH
`define ELGAMAL_MODEXP_ENGINE_CORE_DEFINES_SVH

// cond implies expr in the same cycle
`define EMEC_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("emec check failed");

// cond implies expr in the next cycle
`define EMEC_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("emec check failed");

`endif

>>> rtl/emec_pkg.sv
// Shared types and constants for the ElGamal engine core.
// No dependencies.
package emec_pkg;

  localparam int MOD_WIDTH = 31;
  localparam int FIELD_W   = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR   = 2'd2;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_first;
    logic [FIELD_W-1:0] result_second;
  } out_t;

endpackage

>>> rtl/elgamal_modexp_engine_core.sv
// ElGamal encrypt/decrypt engine top level: config registers, sequencer, result register.
// Depends on emec_pkg, emec_modmul and elgamal_modexp_engine_core_defines.svh.
//
//  channel | ports                     | moves
//  in      | in_valid/in_ready/in_data   | func, operand_a, operand_b
//  out     | out_valid/out_ready/out_data| result_first, result_second
//  cfg     | cfg_we/cfg_idx/cfg_wdata    | modulus, private_key, generator
//
// Each modular multiply runs in the shared emec_modmul unit.
// An exponentiation is at most 1 + 2*MOD_WIDTH multiplies; encrypt runs 3 plus one multiply,
// decrypt 2 plus one.
// A modulus below two skips all work and returns zeros.
// in_ready is high only when idle; a finished result holds until out_ready.
// Synchronous active-low reset restores modulus 23, key 1, generator 5.
`include "elgamal_modexp_engine_core_defines.svh"
module elgamal_modexp_engine_core #(
  parameter int MOD_WIDTH = emec_pkg::MOD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  emec_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output emec_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [emec_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [emec_pkg::FIELD_W-1:0]    cfg_wdata
);
  import emec_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_LDSQ  = 7'b0000100,
    S_BIT   = 7'b0001000,
    S_MULW  = 7'b0010000,
    S_SQW   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  p_r, key_r, gen_r;
  logic          func_r, func_nxt;
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  acc_r, acc_nxt, sq_r, sq_nxt, t_r, t_nxt;
  logic [W-1:0]  first_r, first_nxt, second_r, second_nxt;

  logic          mm_start, mm_done;
  logic [W-1:0]  mm_mcand, mm_mplier, mm_res;
  logic [W-1:0]  pow_base, pow_exp;
  logic          in_xfer, out_xfer;
  logic          mm_wait;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= W'(23);
      key_r <= W'(1);
      gen_r <= W'(5);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODULUS:     p_r   <= cfg_wdata[W-1:0];
        CFG_PRIVATE_KEY: key_r <= cfg_wdata[W-1:0];
        CFG_GENERATOR:   gen_r <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  // base and exponent of the current exponentiation
  always_comb begin
    case (ph_r)
      2'd0: begin
        pow_base = (func_r == FUNC_DECRYPT) ? a_r : gen_r;
        pow_exp  = key_r;
      end
      2'd1: begin
        pow_base = t_r;
        pow_exp  = (func_r == FUNC_DECRYPT) ? p_r - W'(2) : b_r;
      end
      default: begin
        pow_base = gen_r;
        pow_exp  = b_r;
      end
    endcase
  end

  emec_modmul #(.W(W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .mcand   (mm_mcand),
    .mplier  (mm_mplier),
    .modulus (p_r),
    .done    (mm_done),
    .result  (mm_res)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    t_nxt         = t_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    mm_start      = 1'b0;
    mm_mcand      = sq_r;
    mm_mplier     = sq_r;

    if (out_xfer) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt = in_data.func;
          a_nxt    = in_data.operand_a[W-1:0];
          b_nxt    = in_data.operand_b[W-1:0];
          ph_nxt   = 2'd0;
          if (p_r < W'(2)) begin
            first_nxt     = '0;
            second_nxt    = '0;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // sq = base mod p, as 1 * base
        mm_start  = 1'b1;
        mm_mcand  = W'(1);
        mm_mplier = pow_base;
        acc_nxt   = W'(1);
        exp_nxt   = pow_exp;
        cnt_nxt   = '0;
        state_nxt = S_LDSQ;
      end
      S_LDSQ: begin
        if (mm_done) begin
          sq_nxt    = mm_res;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        mm_start = 1'b1;
        if (exp_r[0]) begin
          mm_mcand  = acc_r;
          mm_mplier = sq_r;
          state_nxt = S_MULW;
        end else begin
          state_nxt = S_SQW;
        end
      end
      S_MULW: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          mm_start  = 1'b1;
          state_nxt = S_SQW;
        end
      end
      S_SQW: begin
        if (mm_done) begin
          sq_nxt  = mm_res;
          exp_nxt = exp_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r != LAST) begin
            state_nxt = S_BIT;
          end else if (ph_r == 2'd0) begin
            t_nxt     = acc_r;
            ph_nxt    = 2'd1;
            state_nxt = S_INIT;
          end else if (ph_r == 2'd1 && func_r == FUNC_ENCRYPT) begin
            t_nxt     = acc_r;
            ph_nxt    = 2'd2;
            state_nxt = S_INIT;
          end else if (ph_r == 2'd1) begin
            // decrypt: message = c2 * inverse
            t_nxt     = acc_r;
            mm_start  = 1'b1;
            mm_mcand  = acc_r;
            mm_mplier = b_r;
            state_nxt = S_FIN;
          end else begin
            // encrypt: c1 done, c2 = shared * message
            first_nxt = acc_r;
            mm_start  = 1'b1;
            mm_mcand  = t_r;
            mm_mplier = a_r;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (mm_done && !out_valid_r) begin
          if (func_r == FUNC_DECRYPT) begin
            first_nxt  = mm_res;
            second_nxt = '0;
          end else begin
            second_nxt = mm_res;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= 2'd0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
    end
    func_r   <= func_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    exp_r    <= exp_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    t_r      <= t_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data.result_first  = FIELD_W'(first_r);
  assign out_data.result_second = FIELD_W'(second_r);

  assign mm_wait = (state_r == S_LDSQ) || (state_r == S_MULW) ||
                   (state_r == S_SQW) || (state_r == S_FIN);

  `EMEC_ASSERT_NOW(a_ready_excl, out_valid_r, !in_ready)
  `EMEC_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready)
  `EMEC_ASSERT_NOW(a_done_in_wait, mm_done, mm_wait)
endmodule

>>> rtl/emec_modmul.sv
// Iterative modular multiplier: mcand * mplier mod modulus, one multiplier bit per cycle.
// mcand must be below modulus; mplier may be any value. No dependencies.
module emec_modmul #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] mcand,
  input  logic [W-1:0] mplier,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] result
);
  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  mpl_r, mpl_nxt;
  logic [W-1:0]  mc_r, mc_nxt;
  logic [W:0]    dbl, red1, sum, red2;

  // acc = 2*acc + bit*mcand, kept below modulus by two conditional subtracts
  always_comb begin
    dbl  = {acc_r, 1'b0};
    red1 = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum  = red1 + (mpl_r[W-1] ? {1'b0, mc_r} : '0);
    red2 = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mpl_nxt  = mpl_r;
    mc_nxt   = mc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mpl_nxt  = mplier;
      mc_nxt   = mcand;
    end else if (busy_r) begin
      acc_nxt = red2[W-1:0];
      mpl_nxt = {mpl_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mpl_r <= mpl_nxt;
    mc_r  <= mc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;
endmodule
